// ===== rtl/wes_pkg.sv =====
// Shared types and constants for the weighted entry selector.
package wes_pkg;

   localparam int DEFAULT_MAX_ENTRIES = 256;
   localparam int DEFAULT_WEIGHT_BITS = 16;
   localparam int DEFAULT_GROUP_COUNT = 16;

   localparam int WEIGHT_W = 16;
   localparam int GROUP_W  = 4;
   localparam int SUM_W    = 24;
   localparam int INDEX_W  = 8;
   localparam int ENTRY_W  = 2 * GROUP_W + 1;

   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_SELECT = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      STS_DONE     = 3'd0,
      STS_SELECTED = 3'd1,
      STS_INVALID  = 3'd2,
      STS_BEYOND   = 3'd3,
      STS_FULL     = 3'd4,
      STS_NONE     = 3'd5
   } status_type;

   typedef struct packed {
      cmd_type              command;
      logic [WEIGHT_W-1:0]  weight;
      logic [GROUP_W-1:0]   first_group;
      logic [GROUP_W-1:0]   second_group;
      logic                 entry_valid;
      logic [SUM_W-1:0]     roll;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic [INDEX_W-1:0]   chosen_index;
      logic [GROUP_W-1:0]   chosen_first;
      logic [GROUP_W-1:0]   chosen_second;
      logic [SUM_W-1:0]     total;
   } rsp_type;

endpackage

// ===== rtl/wes_core.sv =====
// Command sequencer with the cumulative-weight and entry memories and the binary search.
module wes_core #(
   parameter int MAX_ENTRIES = wes_pkg::DEFAULT_MAX_ENTRIES,
   parameter int WEIGHT_BITS = wes_pkg::DEFAULT_WEIGHT_BITS,
   parameter int GROUP_COUNT = wes_pkg::DEFAULT_GROUP_COUNT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  wes_pkg::req_type req,
   output logic             res_valid,
   input  logic             res_ready,
   output wes_pkg::rsp_type res
);

   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int SW = wes_pkg::SUM_W;
   localparam int GW = wes_pkg::GROUP_W;
   localparam int WW = wes_pkg::WEIGHT_W;
   localparam int EW = wes_pkg::ENTRY_W;

   localparam logic [63:0] WMAX_WIDE = (64'd1 << WEIGHT_BITS) - 64'd1;
   localparam logic [WW-1:0] WEIGHT_MAX =
      (WEIGHT_BITS >= WW) ? {WW{1'b1}} : WMAX_WIDE[WW-1:0];
   localparam logic [GW-1:0] GROUP_MAX =
      (GROUP_COUNT >= (1 << GW)) ? {GW{1'b1}} : GW'(GROUP_COUNT - 1);
   localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_ENTRIES);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_ENTRY,
      S_RESULT
   } state_type;

   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 any_ff, any_in;
   logic [SW-1:0]        total_ff, total_in;
   logic [CW-1:0]        lo_ff, lo_in;
   logic [CW-1:0]        hi_ff, hi_in;
   logic [IW-1:0]        mid_ff, mid_in;
   logic [SW-1:0]        roll_ff, roll_in;
   wes_pkg::rsp_type     res_ff, res_in;

   logic [SW-1:0]        cum_mem [MAX_ENTRIES];
   logic [EW-1:0]        ent_mem [MAX_ENTRIES];
   logic [SW-1:0]        cum_rd_ff;
   logic [EW-1:0]        ent_rd_ff;
   logic                 cum_rd_en, ent_rd_en, wr_en;
   logic [IW-1:0]        cum_rd_addr, ent_rd_addr, wr_addr;
   logic [SW-1:0]        cum_wr_data;
   logic [EW-1:0]        ent_wr_data;

   logic [WW-1:0]        w_sat;
   logic [GW-1:0]        first_sat, second_sat;
   logic [SW:0]          sum_wide;
   logic [SW-1:0]        sum_sat;
   logic                 below;
   logic [CW-1:0]        lo_next, hi_next, span;

   // Input conditioning for an append.
   assign w_sat      = (req.weight > WEIGHT_MAX) ? WEIGHT_MAX : req.weight;
   assign first_sat  = (req.first_group > GROUP_MAX) ? GROUP_MAX : req.first_group;
   assign second_sat = (req.second_group > GROUP_MAX) ? GROUP_MAX : req.second_group;
   assign sum_wide   = {1'b0, total_ff} + (SW + 1)'(w_sat);
   assign sum_sat    = sum_wide[SW] ? wes_pkg::SUM_MAX : sum_wide[SW-1:0];

   // One search probe: narrow the bound interval on the entry read last cycle.
   assign below   = cum_rd_ff < roll_ff;
   assign lo_next = below ? (CW'(mid_ff) + CW'(1)) : lo_ff;
   assign hi_next = below ? hi_ff : CW'(mid_ff);
   assign span    = hi_next - lo_next;

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_RESULT);
   assign res       = res_ff;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      any_in      = any_ff;
      total_in    = total_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mid_in      = mid_ff;
      roll_in     = roll_ff;
      res_in      = res_ff;
      cum_rd_en   = 1'b0;
      ent_rd_en   = 1'b0;
      cum_rd_addr = mid_ff;
      ent_rd_addr = lo_ff[IW-1:0];
      wr_en       = 1'b0;
      wr_addr     = count_ff[IW-1:0];
      cum_wr_data = sum_sat;
      ent_wr_data = {req.entry_valid, first_sat, second_sat};

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_in   = '{status: wes_pkg::STS_DONE, chosen_index: '0,
                            chosen_first: '0, chosen_second: '0, total: total_ff};
               state_in = S_RESULT;
               unique case (req.command)
                  wes_pkg::CMD_CLEAR: begin
                     count_in     = '0;
                     any_in       = 1'b0;
                     total_in     = '0;
                     res_in.total = '0;
                  end
                  wes_pkg::CMD_APPEND: begin
                     if (count_ff == COUNT_FULL) begin
                        res_in.status = wes_pkg::STS_FULL;
                     end else begin
                        wr_en                = 1'b1;
                        count_in             = count_ff + CW'(1);
                        any_in               = any_ff | req.entry_valid;
                        total_in             = sum_sat;
                        res_in.chosen_index  = wes_pkg::INDEX_W'(count_ff);
                        res_in.chosen_first  = first_sat;
                        res_in.chosen_second = second_sat;
                        res_in.total         = sum_sat;
                     end
                  end
                  wes_pkg::CMD_SELECT: begin
                     if (count_ff == '0 || !any_ff) begin
                        res_in.status = wes_pkg::STS_NONE;
                     end else if (req.roll > total_ff) begin
                        res_in.status = wes_pkg::STS_BEYOND;
                     end else begin
                        // First probe sits in the middle of the whole table.
                        lo_in       = '0;
                        hi_in       = count_ff;
                        mid_in      = IW'(count_ff >> 1);
                        roll_in     = req.roll;
                        cum_rd_en   = 1'b1;
                        cum_rd_addr = IW'(count_ff >> 1);
                        state_in    = S_SEARCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SEARCH: begin
            lo_in = lo_next;
            hi_in = hi_next;
            if (lo_next < hi_next) begin
               mid_in      = IW'(lo_next + (span >> 1));
               cum_rd_en   = 1'b1;
               cum_rd_addr = IW'(lo_next + (span >> 1));
            end else begin
               ent_rd_en   = 1'b1;
               ent_rd_addr = lo_next[IW-1:0];
               state_in    = S_ENTRY;
            end
         end
         S_ENTRY: begin
            res_in.status        = ent_rd_ff[EW-1] ? wes_pkg::STS_SELECTED
                                                   : wes_pkg::STS_INVALID;
            res_in.chosen_index  = wes_pkg::INDEX_W'(lo_ff);
            res_in.chosen_first  = ent_rd_ff[2*GW-1:GW];
            res_in.chosen_second = ent_rd_ff[GW-1:0];
            res_in.total         = total_ff;
            state_in             = S_RESULT;
         end
         S_RESULT: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         any_ff   <= 1'b0;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         any_ff   <= any_in;
         total_ff <= total_in;
      end
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      mid_ff  <= mid_in;
      roll_ff <= roll_in;
      res_ff  <= res_in;
   end

   // Both tables: one write port and one registered read port each.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cum_mem[wr_addr] <= cum_wr_data;
         ent_mem[wr_addr] <= ent_wr_data;
      end
      if (cum_rd_en) begin
         cum_rd_ff <= cum_mem[cum_rd_addr];
      end
      if (ent_rd_en) begin
         ent_rd_ff <= ent_mem[ent_rd_addr];
      end
   end

endmodule

// ===== rtl/weighted_entry_selector.sv =====
// Top level of the weighted entry selector: stream ports and the result register.
//
//   Channel   Direction  Carries
//   req_*     in         clear, append or select command beat
//   rsp_*     out        one status beat per command
//
// Clears, appends, unused commands and selects refused at once have their result registered in
// the core on acceptance and then passed to the result register; the next command beat is taken
// after that hand-off. A searching select probes the cumulative-weight memory through its read
// port once per cycle, at most log2 of the entry count plus one times, then reads the entry
// memory and registers its result. Reset empties the table without clearing the
// memories. A stalled result beat waits in the output register while the next beat is taken.
module weighted_entry_selector #(
   parameter int MAX_ENTRIES = wes_pkg::DEFAULT_MAX_ENTRIES,
   parameter int WEIGHT_BITS = wes_pkg::DEFAULT_WEIGHT_BITS,
   parameter int GROUP_COUNT = wes_pkg::DEFAULT_GROUP_COUNT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // Fields from bit 0: weight, first_group, second_group, entry_valid, roll, zero fill.
   input  logic [55:0] req_tdata,
   // Fields from bit 0: command.
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Fields from bit 0: chosen_index, chosen_first, chosen_second, total.
   output logic [39:0] rsp_tdata,
   // Fields from bit 0: status.
   output logic [2:0]  rsp_tuser
);

   wes_pkg::req_type req;
   wes_pkg::rsp_type res;
   wes_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             res_valid;
   logic             res_ready;

   // Unpack the command beat.
   always_comb begin
      req.command      = wes_pkg::cmd_type'(req_tuser);
      req.weight       = req_tdata[15:0];
      req.first_group  = req_tdata[19:16];
      req.second_group = req_tdata[23:20];
      req.entry_valid  = req_tdata[24];
      req.roll         = req_tdata[48:25];
   end

   wes_core #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .WEIGHT_BITS (WEIGHT_BITS),
      .GROUP_COUNT (GROUP_COUNT)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   // The result register takes a new beat whenever it is empty or being drained.
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.total, rsp_ff.chosen_second, rsp_ff.chosen_first,
                        rsp_ff.chosen_index};
   assign rsp_tuser  = rsp_ff.status;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking stream testbench for the weighted entry selector.
module tb_top;

   // Table geometry and arithmetic limits of the instance under test.
   localparam int MAX_ENTRIES = wes_pkg::DEFAULT_MAX_ENTRIES;
   localparam int WEIGHT_BITS = wes_pkg::DEFAULT_WEIGHT_BITS;
   localparam int GROUP_COUNT = wes_pkg::DEFAULT_GROUP_COUNT;
   localparam int WEIGHT_W    = wes_pkg::WEIGHT_W;
   localparam int GROUP_W     = wes_pkg::GROUP_W;
   localparam int SUM_W       = wes_pkg::SUM_W;
   localparam int INDEX_W     = wes_pkg::INDEX_W;
   localparam logic [WEIGHT_W:0] WEIGHT_CAP = (WEIGHT_W + 1)'((1 << WEIGHT_BITS) - 1);

   // The fourth command code is not used by the block; it must answer with the total only.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS = 1700;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 400000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   weighted_entry_selector dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Shadow copy of the wheel: cumulative weights and the per-entry valid mark and groups.
   logic [SUM_W-1:0]   cum_weight   [MAX_ENTRIES];
   logic               entry_ok     [MAX_ENTRIES];
   logic [GROUP_W-1:0] entry_first  [MAX_ENTRIES];
   logic [GROUP_W-1:0] entry_second [MAX_ENTRIES];
   int                 table_fill;
   logic               have_valid;

   // Outcomes of accepted command beats, oldest first, waiting for their result beats.
   wes_pkg::rsp_type pending_outcomes[$];

   int   error_count;
   int   commands_sent;
   int   cycle_count;
   int   status_tally [8];
   logic steady_mode;     // Both sides stop idling while this is set.
   logic hold_request;    // Asks the result side for one long hold-off.

   function automatic logic [SUM_W-1:0] running_total();
      return (table_fill == 0) ? '0 : cum_weight[table_fill-1];
   endfunction

   // Applies one command to the shadow wheel and returns the result beat it must produce.
   function automatic wes_pkg::rsp_type roulette_predict(input logic [1:0] cmd,
                                                input logic [WEIGHT_W-1:0] weight,
                                                input logic [GROUP_W-1:0] first_grp,
                                                input logic [GROUP_W-1:0] second_grp,
                                                input logic valid,
                                                input logic [SUM_W-1:0] roll);
      wes_pkg::rsp_type  outcome;
      logic [SUM_W:0]    new_sum;
      logic [SUM_W-1:0]  sum_now;
      logic [WEIGHT_W:0] w;
      int                pick;
      outcome = '0;
      sum_now = running_total();
      outcome.status = wes_pkg::STS_DONE;
      outcome.total  = sum_now;
      case (cmd)
         wes_pkg::CMD_CLEAR: begin
            table_fill    = 0;
            have_valid    = 1'b0;
            outcome.total = '0;
         end
         wes_pkg::CMD_APPEND: begin
            if (table_fill >= MAX_ENTRIES) begin
               outcome.status = wes_pkg::STS_FULL;
            end else begin
               w = (weight > WEIGHT_CAP) ? WEIGHT_CAP : {1'b0, weight};
               new_sum = {1'b0, sum_now} + w;
               if (new_sum > wes_pkg::SUM_MAX) new_sum = {1'b0, wes_pkg::SUM_MAX};
               cum_weight[table_fill]   = new_sum[SUM_W-1:0];
               entry_ok[table_fill]     = valid;
               // Group indices beyond the group count saturate to the last group.
               entry_first[table_fill]  = (first_grp >= GROUP_COUNT) ?
                                          GROUP_W'(GROUP_COUNT - 1) : first_grp;
               entry_second[table_fill] = (second_grp >= GROUP_COUNT) ?
                                          GROUP_W'(GROUP_COUNT - 1) : second_grp;
               outcome.chosen_index  = INDEX_W'(table_fill);
               outcome.chosen_first  = entry_first[table_fill];
               outcome.chosen_second = entry_second[table_fill];
               outcome.total         = new_sum[SUM_W-1:0];
               if (valid) have_valid = 1'b1;
               table_fill++;
            end
         end
         wes_pkg::CMD_SELECT: begin
            if (table_fill == 0 || !have_valid) begin
               outcome.status = wes_pkg::STS_NONE;
            end else if (roll > sum_now) begin
               outcome.status = wes_pkg::STS_BEYOND;
            end else begin
               // Cumulative weights never decrease, so the first entry at or above the
               // roll is found by walking from the front.
               pick = 0;
               while (pick < table_fill - 1 && cum_weight[pick] < roll) pick++;
               outcome.status        = entry_ok[pick] ? wes_pkg::STS_SELECTED
                                                      : wes_pkg::STS_INVALID;
               outcome.chosen_index  = INDEX_W'(pick);
               outcome.chosen_first  = entry_first[pick];
               outcome.chosen_second = entry_second[pick];
            end
         end
         default: ;
      endcase
      return outcome;
   endfunction

   // Offers one command beat, idling at random first, and records its outcome once the
   // beat is accepted. Valid stays high afterwards so back-to-back beats need no gap.
   task automatic offer_command(input logic [1:0] cmd, input logic [WEIGHT_W-1:0] weight,
                                input logic [GROUP_W-1:0] first_grp,
                                input logic [GROUP_W-1:0] second_grp,
                                input logic valid, input logic [SUM_W-1:0] roll);
      wes_pkg::rsp_type outcome;
      while (!steady_mode && $urandom_range(0, 99) < 14) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {7'b0, roll, valid, second_grp, first_grp, weight};
      do @(posedge clock); while (req_tready !== 1'b1);
      outcome = roulette_predict(cmd, weight, first_grp, second_grp, valid, roll);
      pending_outcomes.insert(pending_outcomes.size(), outcome);
      commands_sent++;
   endtask

   // The fields a command does not use carry random bits, which the block must ignore.
   task automatic clear_table();
      offer_command(wes_pkg::CMD_CLEAR, WEIGHT_W'($urandom), GROUP_W'($urandom),
                    GROUP_W'($urandom), 1'($urandom), SUM_W'($urandom));
   endtask

   task automatic append_entry(input logic [WEIGHT_W-1:0] weight,
                               input logic [GROUP_W-1:0] first_grp,
                               input logic [GROUP_W-1:0] second_grp, input logic valid);
      offer_command(wes_pkg::CMD_APPEND, weight, first_grp, second_grp, valid,
                    SUM_W'($urandom));
   endtask

   task automatic select_roll(input logic [SUM_W-1:0] roll);
      offer_command(wes_pkg::CMD_SELECT, WEIGHT_W'($urandom), GROUP_W'($urandom),
                    GROUP_W'($urandom), 1'($urandom), roll);
   endtask

   task automatic issue_unused();
      offer_command(CMD_UNUSED, WEIGHT_W'($urandom), GROUP_W'($urandom),
                    GROUP_W'($urandom), 1'($urandom), SUM_W'($urandom));
   endtask

   function automatic logic [WEIGHT_W-1:0] random_weight();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3:    return WEIGHT_W'($urandom_range(0, 255));
         default: return WEIGHT_W'($urandom);
      endcase
   endfunction

   function automatic logic [GROUP_W-1:0] random_group();
      return GROUP_W'($urandom);
   endfunction

   // Rolls mostly land on the wheel; the rest probe both ends and the space past the total.
   function automatic logic [SUM_W-1:0] random_roll();
      logic [SUM_W-1:0] sum_now;
      sum_now = running_total();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return sum_now;
         2: return (sum_now == wes_pkg::SUM_MAX) ? sum_now :
                   SUM_W'($urandom_range(sum_now + 1, wes_pkg::SUM_MAX));
         3: return SUM_W'($urandom);
         default: return SUM_W'($urandom_range(0, sum_now));
      endcase
   endfunction

   // An empty wheel, and a wheel that holds only entries that may not be chosen.
   task automatic test_empty_wheel();
      select_roll('0);
      issue_unused();
      append_entry(16'd500, 4'd3, 4'd9, 1'b0);
      select_roll(24'd200);
      select_roll(wes_pkg::SUM_MAX);
   endtask

   // Zero weight at the front, extreme weights and groups, and the edges of the roll range.
   task automatic test_wheel_edges();
      clear_table();
      append_entry('0, '0, '1, 1'b1);
      append_entry('1, '1, '0, 1'b0);
      append_entry(16'd1, 4'd5, 4'd10, 1'b1);
      select_roll('0);
      select_roll(24'd1);
      select_roll(24'd65535);
      select_roll(24'd65536);
      select_roll(24'd65537);
      select_roll(wes_pkg::SUM_MAX);
      issue_unused();
      clear_table();
      // A zero-weight entry that may not be chosen sits in front of a valid one.
      append_entry('0, 4'd7, 4'd8, 1'b0);
      append_entry(16'd40, 4'd1, 4'd2, 1'b1);
      select_roll('0);
      select_roll(24'd40);
      clear_table();
      select_roll('0);
   endtask

   // Fills all entries with the largest weight, then pushes appends into the full wheel.
   task automatic test_full_wheel();
      clear_table();
      repeat (MAX_ENTRIES) begin
         append_entry('1, random_group(), random_group(), $urandom_range(0, 3) != 0);
      end
      append_entry(random_weight(), random_group(), random_group(), 1'b1);
      append_entry('0, '0, '0, 1'b0);
      select_roll('0);
      select_roll(running_total());
      select_roll(running_total() + 24'd1);
      repeat (6) select_roll(random_roll());
      clear_table();
   endtask

   // The result side holds off for a long stretch while command beats keep coming, so the
   // block must fill its output register and stall the command side.
   task automatic test_result_backpressure();
      hold_request = 1'b1;
      clear_table();
      repeat (8) append_entry(random_weight(), random_group(), random_group(), 1'($urandom));
      repeat (14) select_roll(random_roll());
   endtask

   // Mostly well-formed sequences: an optional clear, a run of appends, then selects.
   // Skipped clears let the wheel grow until it is full. About one in seven rounds is noise.
   task automatic test_random_traffic();
      int counted;
      int entries;
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         steady_mode = (counted >= 600 && counted < 900);
         if ($urandom_range(0, 99) < 85) begin
            if ($urandom_range(0, 3) != 0) begin
               clear_table();
               counted++;
            end
            case ($urandom_range(0, 19))
               0:       entries = $urandom_range(100, 260);
               1, 2, 3: entries = $urandom_range(13, 40);
               default: entries = $urandom_range(1, 12);
            endcase
            repeat (entries) begin
               append_entry(random_weight(), random_group(), random_group(),
                            $urandom_range(0, 3) != 0);
               counted++;
            end
            repeat ($urandom_range(1, 12)) begin
               select_roll(random_roll());
               counted++;
            end
         end else begin
            case ($urandom_range(0, 3))
               0: issue_unused();
               1: begin
                  clear_table();
                  counted++;
               end
               2: begin
                  select_roll(SUM_W'($urandom));
                  counted++;
               end
               default: begin
                  append_entry(random_weight(), random_group(), random_group(),
                               1'($urandom));
                  counted++;
               end
            endcase
         end
      end
      steady_mode = 1'b0;
   endtask

   // The result side: random idle cycles, none during the steady stretch, and one long
   // hold-off counted here when a test asks for it.
   initial begin : drive_result_ready
      int hold_left;
      hold_left  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady_mode || ($urandom_range(0, 99) >= 14);
         end
      end
   end

   function automatic void compare_field(input string label, input logic [23:0] want,
                                         input logic [23:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         error_count++;
      end
   endfunction

   // Every accepted result beat is checked against the oldest outstanding outcome.
   always @(posedge clock) begin : check_results
      wes_pkg::rsp_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (pending_outcomes.size() == 0) begin
            $display("%0t: result beat with nothing outstanding, status %0d, total %0d",
                     $time, rsp_tuser, rsp_tdata[39:16]);
            error_count++;
         end else begin
            want = pending_outcomes.pop_front();
            status_tally[want.status]++;
            compare_field("status", 24'(want.status), 24'(rsp_tuser));
            compare_field("chosen_index", 24'(want.chosen_index), 24'(rsp_tdata[7:0]));
            compare_field("chosen_first", 24'(want.chosen_first), 24'(rsp_tdata[11:8]));
            compare_field("chosen_second", 24'(want.chosen_second), 24'(rsp_tdata[15:12]));
            compare_field("total", want.total, rsp_tdata[39:16]);
         end
      end
   end

   always @(posedge clock) cycle_count++;

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("%0t: timed out with %0d outcomes outstanding", $time,
               pending_outcomes.size());
      $display("weighted_entry_selector regression: fail");
      $finish;
   end

   initial begin : run_tests
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = '0;
      error_count   = 0;
      commands_sent = 0;
      cycle_count   = 0;
      steady_mode   = 1'b0;
      hold_request  = 1'b0;
      table_fill    = 0;
      have_valid    = 1'b0;
      foreach (status_tally[i]) status_tally[i] = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_wheel();
      test_wheel_edges();
      test_full_wheel();
      test_result_backpressure();
      test_random_traffic();

      req_tvalid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d commands: %0d selections, %0d invalid hits, %0d rolls past total,",
               commands_sent, status_tally[wes_pkg::STS_SELECTED],
               status_tally[wes_pkg::STS_INVALID], status_tally[wes_pkg::STS_BEYOND]);
      $display("%0d appends into a full wheel, %0d selects with nothing valid; %0d errors.",
               status_tally[wes_pkg::STS_FULL], status_tally[wes_pkg::STS_NONE],
               error_count);
      if (error_count == 0) begin
         $display("weighted_entry_selector regression: pass");
      end else begin
         $display("weighted_entry_selector regression: fail");
      end
      $finish;
   end

endmodule
